FILE: design/sfh_pkg.sv
`timescale 1ns / 1ps

package sfh_pkg;

    // FNV-1a bases and primes
    localparam logic [31:0] FNV_BASIS32 = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME32 = 32'd16777619;
    localparam logic [63:0] FNV_BASIS64 = 64'd14695981039346656037;
    localparam logic [63:0] FNV_PRIME64 = 64'd1099511628211;

    // fmix multipliers
    localparam logic [31:0] FMIX32_C1 = 32'h7feb352d;
    localparam logic [31:0] FMIX32_C2 = 32'h846ca68b;
    localparam logic [63:0] FMIX64_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX64_C2 = 64'hc4ceb9fe1a85ec53;

    // multiplier digit slicing
    localparam int unsigned DIGIT_W    = 16;
    localparam int unsigned NUM_DIGITS = 64 / DIGIT_W;
    localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS);

    // register map
    localparam logic [7:0] REG_HASH_SEED = 8'd0;
    localparam logic [7:0] REG_WIDE_MODE = 8'd1;

    // finalizer round codes
    localparam logic [1:0] FIN_ROUND0 = 2'd0;
    localparam logic [1:0] FIN_ROUND1 = 2'd1;
    localparam logic [1:0] FIN_ROUND2 = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MUL   = 3'b010,
        ST_SHIFT = 3'b100
    } t_state;

    function automatic logic [63:0] start_value(input logic [63:0] seed, input logic wide);
        if (wide) begin
            return FNV_BASIS64 ^ seed;
        end
        return {32'd0, FNV_BASIS32 ^ seed[31:0]};
    endfunction

endpackage

FILE: design/seeded_fnv1a_fmix_string_hash.sv
`timescale 1ns / 1ps

// Seeded FNV-1a string hash with a murmur-style fmix finalizer. Send a string one
// byte per request (i_has_byte=1), marking the final request with i_last; a request
// with i_has_byte=0 and i_last=1 hashes the empty string (or finalizes whatever has
// been absorbed). One hash comes out per string on o_hash_value, upper 32 bits zero
// in 32-bit mode. Register 0 is the 64-bit seed (reset 1), register 1 bit 0 picks
// 64-bit mode (reset 0); a write to either register restarts the running hash from
// the basis XOR seed, so write only between strings. All multiplies run on one
// shared 64x16 multiply-accumulate unit, four digit passes per multiply: a data
// byte is accepted and then multiplied, and the final request adds three xor-shift
// steps and two multiplies. The block takes no new request while it works; a
// finished hash sits in its own output register, so the next string can start
// while the hash still waits to be taken.
module seeded_fnv1a_fmix_string_hash
    import sfh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte requests
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    // hash results
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash_value,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_state                 r_state, n_state;
    logic [63:0]            r_seed, n_seed;
    logic                   r_mode, n_mode;
    logic [63:0]            r_running, n_running;
    logic                   r_last, n_last;
    logic [1:0]             r_fin, n_fin;
    logic [63:0]            r_x, n_x;
    logic [63:0]            r_a, n_a;
    logic [63:0]            r_b, n_b;
    logic [63:0]            r_acc, n_acc;
    logic [DIG_CNT_W-1:0]   r_dig, n_dig;
    logic [63:0]            r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic [63+DIGIT_W:0]    w_pp;
    logic [63:0]            w_sum;
    logic [63:0]            w_mul_res;
    logic [63:0]            w_xs;
    logic [63:0]            w_absorb;

    assign o_ready      = (r_state == ST_IDLE);
    assign o_cfg_ready  = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

    // Shared multiply-accumulate: one 64x16 partial product per cycle.
    assign w_pp      = {{DIGIT_W{1'b0}}, r_a} * {64'd0, r_b[DIGIT_W-1:0]};
    assign w_sum     = r_acc + w_pp[63:0];
    assign w_mul_res = r_mode ? w_sum : {32'd0, w_sum[31:0]};

    // Xor-shift step of the finalizer; narrow mode uses 16, 15, 16.
    always_comb begin
        if (r_mode) begin
            w_xs = r_x ^ (r_x >> 33);
        end else if (r_fin == FIN_ROUND1) begin
            w_xs = r_x ^ (r_x >> 15);
        end else begin
            w_xs = r_x ^ (r_x >> 16);
        end
    end

    assign w_absorb = r_mode ? (r_running ^ {56'd0, i_data_byte})
                             : {32'd0, r_running[31:0] ^ {24'd0, i_data_byte}};

    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_mode      = r_mode;
        n_running   = r_running;
        n_last      = r_last;
        n_fin       = r_fin;
        n_x         = r_x;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_dig       = r_dig;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_last = i_last;
                    n_fin  = FIN_ROUND0;
                    if (i_has_byte) begin
                        // absorb: (h ^ byte) * prime
                        n_a     = w_absorb;
                        n_b     = r_mode ? FNV_PRIME64 : {32'd0, FNV_PRIME32};
                        n_acc   = '0;
                        n_dig   = '0;
                        n_state = ST_MUL;
                    end else if (i_last) begin
                        n_x     = r_running;
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_MUL: begin
                n_acc = w_sum;
                n_a   = r_a << DIGIT_W;
                n_b   = r_b >> DIGIT_W;
                n_dig = r_dig + 1'b1;
                if (r_dig == DIG_CNT_W'(NUM_DIGITS - 1)) begin
                    n_x = w_mul_res;
                    if (r_fin == FIN_ROUND0) begin
                        // absorb multiply done
                        n_running = w_mul_res;
                        n_state   = r_last ? ST_SHIFT : ST_IDLE;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (r_fin == FIN_ROUND2) begin
                    // hold the final step until the output register is free
                    if (!r_out_valid || i_ready) begin
                        n_out       = w_xs;
                        n_out_valid = 1'b1;
                        n_running   = start_value(r_seed, r_mode);
                        n_fin       = FIN_ROUND0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_a     = w_xs;
                    n_acc   = '0;
                    n_dig   = '0;
                    n_fin   = r_fin + 2'd1;
                    n_state = ST_MUL;
                    if (r_fin == FIN_ROUND0) begin
                        n_b = r_mode ? FMIX64_C1 : {32'd0, FMIX32_C1};
                    end else begin
                        n_b = r_mode ? FMIX64_C2 : {32'd0, FMIX32_C2};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // writes to either register restart the running hash
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HASH_SEED: begin
                    n_seed    = i_cfg_data;
                    n_running = start_value(i_cfg_data, r_mode);
                end
                REG_WIDE_MODE: begin
                    n_mode    = i_cfg_data[0];
                    n_running = start_value(r_seed, i_cfg_data[0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= 64'd1;
            r_mode      <= 1'b0;
            r_running   <= start_value(64'd1, 1'b0);
            r_fin       <= FIN_ROUND0;
            r_dig       <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_mode      <= n_mode;
            r_running   <= n_running;
            r_fin       <= n_fin;
            r_dig       <= n_dig;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_out <= n_out;
    end

`ifndef ASSERT_OFF
    a_dig_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MUL) |-> (r_dig == '0))
        else $error("digit counter nonzero outside multiply");

    a_fin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin != 2'd3)
        else $error("finalizer round out of range");

    a_narrow_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode |-> (r_running[63:32] == 32'd0))
        else $error("running hash has upper bits set in 32-bit mode");

    a_narrow_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_mode) |-> (r_out[63:32] == 32'd0))
        else $error("32-bit hash has upper bits set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending hash overwritten");
`endif

endmodule
